### sv/bloom_filter_two_hash_top_macros.svh
// Assertion macros for the two-hash bloom filter.
`ifndef BLOOM_FILTER_TWO_HASH_TOP_MACROS_SVH
`define BLOOM_FILTER_TWO_HASH_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BFTH_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bfth same-cycle check failed");
`define BFTH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bfth next-cycle check failed");
`else
`define BFTH_ASSERT_SAME(label, ante, cons)
`define BFTH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### sv/bfth_pkg.sv
// Shared types and constants for the two-hash bloom filter.
`default_nettype none

package bfth_pkg;

  localparam int HASH_W       = 32;
  localparam int HASH_CNT_W   = $clog2(HASH_W + 1);
  localparam int BYTE_W       = 8;
  localparam int ARRAY_BITS_W = 23;
  localparam int HASH_COUNT_W = 2;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;
  localparam int ROW_W        = 32;
  localparam int BIT_SEL_W    = 5;

  localparam logic [ARRAY_BITS_W-1:0] ARRAY_BITS_RESET = 23'd2500000;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RESET = 2'd2;
  localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_NONE  = 2'd0;

  // Register select: word address bit of paddr
  localparam logic REG_ARRAY_BITS = 1'b0;
  localparam logic REG_HASH_COUNT = 1'b1;

  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_READ,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic valid;
    logic set;
  } store_ctl_t;

  typedef struct packed {
    logic clearing;
    logic hit;
  } store_stat_t;

endpackage

`default_nettype wire

### sv/bfth_hash.sv
// Running shift-add-xor and sdbm hashes over the key bytes.
`default_nettype none

module bfth_hash
  import bfth_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              byte_valid,
  input  wire logic              last,
  input  wire logic [BYTE_W-1:0] key_byte,
  output logic      [HASH_W-1:0] sax_fin,
  output logic      [HASH_W-1:0] sdbm_fin
);

  logic [HASH_W-1:0] sax_acc;
  logic [HASH_W-1:0] sdbm_acc;
  logic [HASH_W-1:0] byte_ext;
  logic [HASH_W-1:0] sax_upd;
  logic [HASH_W-1:0] sdbm_upd;
  logic [HASH_W-1:0] sax_cur;
  logic [HASH_W-1:0] sdbm_cur;

  always_comb begin
    byte_ext = HASH_W'(key_byte);
    sax_upd  = sax_acc ^ ((sax_acc << 5) + (sax_acc >> 2) + byte_ext);
    sdbm_upd = byte_ext + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
    sax_cur  = byte_valid ? sax_upd : sax_acc;
    sdbm_cur = byte_valid ? sdbm_upd : sdbm_acc;
  end

  // Fold each accepted byte into the accumulators; closing the key restarts them
  always_ff @(posedge clk) begin
    if (rst) begin
      sax_acc  <= '0;
      sdbm_acc <= '0;
    end else if (accept) begin
      if (last) begin
        sax_acc  <= '0;
        sdbm_acc <= '0;
      end else begin
        sax_acc  <= sax_cur;
        sdbm_acc <= sdbm_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      sax_fin  <= sax_cur;
      sdbm_fin <= sdbm_cur;
    end
  end

endmodule

`default_nettype wire

### sv/bfth_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none

module bfth_mod
  import bfth_pkg::*;
#(
  parameter int MW = 23
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [HASH_W-1:0] dividend,
  input  wire logic [MW-1:0]     divisor,
  output logic                   done,
  output logic      [MW-1:0]     rem
);

  logic [HASH_W-1:0]     dvd;
  logic [MW-1:0]         m;
  logic [HASH_CNT_W-1:0] cnt;
  logic [MW:0]           trial;
  logic [MW:0]           diff;
  logic                  ge;

  always_comb begin
    trial = {rem, dvd[HASH_W-1]};
    diff  = trial - {1'b0, m};
    ge    = (trial >= {1'b0, m});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= HASH_CNT_W'(HASH_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == HASH_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder stays below m, so the trial is below 2m and one subtract restores it
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      m   <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= dvd << 1;
      rem <= ge ? diff[MW-1:0] : trial[MW-1:0];
    end
  end

endmodule

`default_nettype wire

### sv/bfth_store.sv
// Filter bit store: 32-bit rows, read-modify-write, cleared after reset.
`default_nettype none

module bfth_store
  import bfth_pkg::*;
#(
  parameter int MAX_BITS = 4194304,
  parameter int MW       = 23
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire store_ctl_t    ctl,
  input  wire logic [MW-1:0] idx,
  output store_stat_t        stat
);

  localparam int ROWS = (MAX_BITS + ROW_W - 1) / ROW_W;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int XW   = MW + BIT_SEL_W;

  logic [ROW_W-1:0]     mem [ROWS];
  logic [ROW_W-1:0]     rdata;
  logic [XW-1:0]        idx_ext;
  logic [RW-1:0]        rd_row;
  logic [RW-1:0]        pend_row;
  logic [BIT_SEL_W-1:0] pend_bit;
  logic                 pend;
  logic                 pend_set;
  logic                 clearing;
  logic [RW-1:0]        clr_row;

  always_comb begin
    idx_ext       = XW'(idx);
    rd_row        = idx_ext[BIT_SEL_W +: RW];
    stat.clearing = clearing;
    stat.hit      = rdata[pend_bit];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      clearing <= 1'b1;
      clr_row  <= '0;
    end else begin
      pend <= ctl.valid;
      if (clearing) begin
        clr_row <= clr_row + 1'b1;
        if (clr_row == RW'(ROWS - 1)) begin
          clearing <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      pend_row <= rd_row;
      pend_bit <= idx_ext[BIT_SEL_W-1:0];
      pend_set <= ctl.set;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      rdata <= mem[rd_row];
    end
  end

  // One write port: clearing pass, else the set half of a read-modify-write
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_row] <= '0;
    end else if (pend && pend_set) begin
      mem[pend_row] <= rdata | (ROW_W'(1) << pend_bit);
    end
  end

endmodule

`default_nettype wire

### sv/bloom_filter_two_hash_top.sv
// Two-hash bloom filter top level: control, registers and result.
//
// Keys come in one byte per start beat. On the last beat each enabled hash is
// reduced to a bit index by a shared remainder unit (one dividend bit per cycle)
// and then goes to the bit store for one read and, on an add, a write back; busy
// stays high through this for each hash, and with hash_count zero the key is
// answered at once. After reset the store runs a clearing pass over
// ceil(MAX_BITS/32) rows (131072 at the default size); busy stays high through
// it until the control leaves its clear state. Each result is a single-cycle
// result_valid strobe; the receiver cannot stall it.
`default_nettype none
`include "bloom_filter_two_hash_top_macros.svh"

module bloom_filter_two_hash_top
  import bfth_pkg::*;
#(
  parameter int MAX_BITS = 4194304
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              func,
  input  wire logic [BYTE_W-1:0] key_byte,
  input  wire logic              byte_valid,
  input  wire logic              last,
  output logic                   result_valid,
  output logic                   op_done,
  output logic                   present,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int MW = $clog2(MAX_BITS + 1);
  localparam int CW = (MW > ARRAY_BITS_W) ? MW : ARRAY_BITS_W;

  state_t                  state;
  state_t                  state_next;
  logic [ARRAY_BITS_W-1:0] array_bits;
  logic [HASH_COUNT_W-1:0] hash_count;
  logic                    func_q;
  logic                    use_two;
  logic                    hash_sel;
  logic                    present_acc;
  logic                    present_acc_next;
  logic                    accept;
  logic                    cfg_wr;
  logic                    more_hash;
  logic [CW-1:0]           m_ext;
  logic [CW-1:0]           m_sat;
  logic [MW-1:0]           modulus;
  logic [HASH_W-1:0]       sax_fin;
  logic [HASH_W-1:0]       sdbm_fin;
  logic [HASH_W-1:0]       dividend;
  logic                    div_start;
  logic                    div_done;
  logic [MW-1:0]           div_rem;
  store_ctl_t              store_ctl;
  store_stat_t             store_st;

  bfth_hash u_hash (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_valid (byte_valid),
    .last       (last),
    .key_byte   (key_byte),
    .sax_fin    (sax_fin),
    .sdbm_fin   (sdbm_fin)
  );

  bfth_mod #(.MW(MW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (modulus),
    .done     (div_done),
    .rem      (div_rem)
  );

  bfth_store #(.MAX_BITS(MAX_BITS), .MW(MW)) u_store (
    .clk  (clk),
    .rst  (rst),
    .ctl  (store_ctl),
    .idx  (div_rem),
    .stat (store_st)
  );

  // Modulus: zero acts as one, saturate at the store size
  always_comb begin
    m_ext = CW'(array_bits);
    if (array_bits == '0) begin
      m_sat = CW'(1);
    end else if (m_ext > CW'(MAX_BITS)) begin
      m_sat = CW'(MAX_BITS);
    end else begin
      m_sat = m_ext;
    end
    modulus = m_sat[MW-1:0];
  end

  always_comb begin
    accept           = start && !busy;
    cfg_wr           = psel && penable && pwrite && pready;
    more_hash        = use_two && !hash_sel;
    present_acc_next = present_acc && store_st.hit;
    dividend         = hash_sel ? sdbm_fin : sax_fin;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (!store_st.clearing) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && last && (hash_count != HASH_COUNT_NONE)) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        state_next = more_hash ? ST_LOAD : ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    busy            = 1'b1;
    div_start       = 1'b0;
    store_ctl.valid = 1'b0;
    store_ctl.set   = (func_q == FUNC_ADD);
    unique case (state) inside
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_LOAD: begin
        div_start = 1'b1;
      end
      ST_READ: begin
        store_ctl.valid = 1'b1;
      end
      ST_CLEAR, ST_DIV, ST_WAIT: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      result_valid <= 1'b0;
      array_bits   <= ARRAY_BITS_RESET;
      hash_count   <= HASH_COUNT_RESET;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_ARRAY_BITS: array_bits <= pwdata[ARRAY_BITS_W-1:0];
          REG_HASH_COUNT: hash_count <= pwdata[HASH_COUNT_W-1:0];
          default: begin
            array_bits <= array_bits;
          end
        endcase
      end
      // Key closed with no hash in use: answer at once
      if (accept && last && (hash_count == HASH_COUNT_NONE)) begin
        result_valid <= 1'b1;
      end
      if ((state == ST_WAIT) && !more_hash) begin
        result_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      func_q      <= func;
      use_two     <= hash_count[1];
      hash_sel    <= 1'b0;
      present_acc <= 1'b1;
      if (hash_count == HASH_COUNT_NONE) begin
        op_done <= func;
        present <= (func == FUNC_CHECK);
      end
    end else if (state == ST_WAIT) begin
      present_acc <= present_acc_next;
      if (more_hash) begin
        hash_sel <= 1'b1;
      end else begin
        op_done <= func_q;
        present <= (func_q == FUNC_CHECK) && present_acc_next;
      end
    end
  end

  always_comb begin
    pready = 1'b1;
    unique case (paddr[2])
      REG_ARRAY_BITS: prdata = DATA_W'(array_bits);
      REG_HASH_COUNT: prdata = DATA_W'(hash_count);
      default:        prdata = '0;
    endcase
  end

  `BFTH_ASSERT_SAME(a_store_not_while_clearing, store_ctl.valid, !store_st.clearing)
  `BFTH_ASSERT_SAME(a_div_done_in_div, div_done, state == ST_DIV)
  `BFTH_ASSERT_NEXT(a_wait_ends_in_result, (state == ST_WAIT) && !more_hash, result_valid)
  `BFTH_ASSERT_SAME(a_result_source, result_valid, $past(state == ST_WAIT) || $past(accept && last))

endmodule

`default_nettype wire
